FILE: hdl/frv_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the record validator.
// No dependencies; imported by frv_regs and factory_record_validator.
package frv_pkg;

  localparam int DEF_MAX_NAME_LEN    = 64;
  localparam int DEF_MAX_DATASET_LEN = 254;

  localparam logic [15:0] HDR_BYTES = 16'd10;
  localparam logic [15:0] TRAILER_BYTES = 16'd4;
  localparam logic [15:0] POS_VERSION = 16'd4;
  localparam logic [15:0] POS_NAME_LEN = 16'd5;
  localparam logic [15:0] POS_DS_LO = 16'd6;
  localparam logic [15:0] POS_DS_HI = 16'd7;
  localparam logic [15:0] POS_PORT_LO = 16'd8;
  localparam logic [15:0] POS_PORT_HI = 16'd9;
  localparam logic [15:0] MAGIC_BYTES = 16'd4;

  localparam logic [7:0] MAGIC [4] = '{8'h54, 8'h58, 8'h4E, 8'h31};
  localparam logic [7:0] CHAR_LO = 8'h21;  // '!'
  localparam logic [7:0] CHAR_HI = 8'h7E;  // '~'

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] VERSION_RESET = 8'd1;

  // register indexes
  localparam logic REG_VERSION = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_NAME   = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_NAME    = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/factory_record_validator.sv
// Top level of the framed record validator: byte parser, header checks and CRC-32.
// Depends on frv_pkg and frv_regs.
//
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid/in_ready   | in_data_byte, in_record_start
//  out_     | output    | out_valid/out_ready | out_status, out_name_length,
//           |           |                     | out_dataset_length, out_service_port
//  cfg      | input     | psel/penable/pready | paddr, pwdata, prdata
//
// One byte per cycle while the output is not stalled: an input register feeds the
// parser and CRC step; the result of a record's last byte goes to the output register.
// A byte leaves the input register whenever the output register is empty or is being
// taken, so a stalled output holds at most one byte in the input register.
// Reset is synchronous, active low, and clears the parser to idle; no clearing pass.
module factory_record_validator import frv_pkg::*; #(
  parameter int MAX_NAME_LEN    = DEF_MAX_NAME_LEN,
  parameter int MAX_DATASET_LEN = DEF_MAX_DATASET_LEN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_record_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [6:0]  out_name_length,
  output logic [7:0]  out_dataset_length,
  output logic [15:0] out_service_port,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] expected_version;

  frv_regs u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .expected_version (expected_version)
  );

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       proc_go;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  name_r, name_nxt;
  logic [15:0] ds_r, ds_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] stored_r, stored_nxt;

  // output register
  logic        out_vld_r;
  status_t     status_r;
  logic [6:0]  name_out_r;
  logic [7:0]  ds_out_r;
  logic [15:0] port_out_r;

  // effective state after a possible restart
  phase_t      eff_phase;
  logic [15:0] eff_pos, pos_inc;
  logic [7:0]  eff_name;
  logic [15:0] eff_ds, eff_port;
  logic [31:0] eff_crc, eff_stored, crc_upd;
  logic [15:0] ds_full, port_full;

  logic    fail, done, fin;
  status_t res_status;

  assign proc_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_record_start;
    end
  end

  assign eff_phase  = in_start_r ? PH_HEADER : phase_r;
  assign eff_pos    = in_start_r ? 16'h0 : pos_r;
  assign eff_name   = in_start_r ? 8'h0 : name_r;
  assign eff_ds     = in_start_r ? 16'h0 : ds_r;
  assign eff_port   = in_start_r ? 16'h0 : port_r;
  assign eff_crc    = in_start_r ? CRC_INIT : crc_r;
  assign eff_stored = in_start_r ? 32'h0 : stored_r;
  assign pos_inc    = eff_pos + 16'd1;
  assign crc_upd    = crc_byte(eff_crc, in_byte_r);
  assign ds_full    = {in_byte_r, eff_ds[7:0]};
  assign port_full  = {in_byte_r, eff_port[7:0]};
  assign stored_nxt = {in_byte_r, eff_stored[31:8]};

  // checks and result status
  always_comb begin
    fail       = 1'b0;
    done       = 1'b0;
    res_status = ST_OK;
    case (eff_phase)
      PH_HEADER: begin
        if (eff_pos < MAGIC_BYTES) begin
          if (in_byte_r != MAGIC[eff_pos[1:0]]) begin
            fail       = 1'b1;
            res_status = ST_MAGIC;
          end
        end else if (eff_pos == POS_VERSION) begin
          if (in_byte_r != expected_version) begin
            fail       = 1'b1;
            res_status = ST_VERSION;
          end
        end else if (eff_pos == POS_NAME_LEN) begin
          if (in_byte_r == 8'h0 || 32'(in_byte_r) > MAX_NAME_LEN) begin
            fail       = 1'b1;
            res_status = ST_LENGTH;
          end
        end else if (eff_pos == POS_DS_HI) begin
          if (ds_full == 16'h0 || 32'(ds_full) > MAX_DATASET_LEN) begin
            fail       = 1'b1;
            res_status = ST_LENGTH;
          end
        end else if (eff_pos == POS_PORT_HI) begin
          if (port_full == 16'h0) begin
            fail       = 1'b1;
            res_status = ST_LENGTH;
          end
        end
      end
      PH_NAME: begin
        if (in_byte_r < CHAR_LO || in_byte_r > CHAR_HI) begin
          fail       = 1'b1;
          res_status = ST_NAME;
        end
      end
      PH_CRC: begin
        if (pos_inc >= TRAILER_BYTES) begin
          done       = 1'b1;
          res_status = ((~eff_crc) == stored_nxt) ? ST_OK : ST_CRC;
        end
      end
      default: ;
    endcase
  end

  assign fin = fail || done;

  // next phase and byte position
  always_comb begin
    phase_nxt = eff_phase;
    pos_nxt   = pos_inc;
    if (fin) begin
      phase_nxt = PH_IDLE;
      pos_nxt   = 16'h0;
    end else begin
      case (eff_phase)
        PH_HEADER: begin
          if (pos_inc >= HDR_BYTES) begin
            phase_nxt = PH_NAME;
            pos_nxt   = 16'h0;
          end
        end
        PH_NAME: begin
          if (pos_inc >= {8'h0, eff_name}) begin
            phase_nxt = PH_DATA;
            pos_nxt   = 16'h0;
          end
        end
        PH_DATA: begin
          if (pos_inc >= eff_ds) begin
            phase_nxt = PH_CRC;
            pos_nxt   = 16'h0;
          end
        end
        PH_CRC: ;
        default: begin
          phase_nxt = PH_IDLE;
          pos_nxt   = eff_pos;
        end
      endcase
    end
  end

  // header fields and CRC
  always_comb begin
    name_nxt = eff_name;
    ds_nxt   = eff_ds;
    port_nxt = eff_port;
    crc_nxt  = eff_crc;
    case (eff_phase)
      PH_HEADER: begin
        crc_nxt = crc_upd;
        if (eff_pos == POS_NAME_LEN) begin
          name_nxt = in_byte_r;
        end else if (eff_pos == POS_DS_LO) begin
          ds_nxt = {8'h0, in_byte_r};
        end else if (eff_pos == POS_DS_HI) begin
          ds_nxt = ds_full;
        end else if (eff_pos == POS_PORT_LO) begin
          port_nxt = {8'h0, in_byte_r};
        end else if (eff_pos == POS_PORT_HI) begin
          port_nxt = port_full;
        end
      end
      PH_NAME: begin
        if (!fail) begin
          crc_nxt = crc_upd;
        end
      end
      PH_DATA: crc_nxt = crc_upd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 16'h0;
    end else if (proc_go) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      name_r <= name_nxt;
      ds_r   <= ds_nxt;
      port_r <= port_nxt;
      crc_r  <= crc_nxt;
      if (eff_phase == PH_CRC) begin
        stored_r <= stored_nxt;
      end else begin
        stored_r <= eff_stored;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && fin) begin
      status_r <= res_status;
      if (res_status == ST_OK) begin
        name_out_r <= eff_name[6:0];
        ds_out_r   <= eff_ds[7:0];
        port_out_r <= eff_port;
      end else begin
        name_out_r <= 7'h0;
        ds_out_r   <= 8'h0;
        port_out_r <= 16'h0;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = status_r;
  assign out_name_length    = name_out_r;
  assign out_dataset_length = ds_out_r;
  assign out_service_port   = port_out_r;

  // a failed record reports no header values
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r != ST_OK) |->
      (name_out_r == 7'h0 && ds_out_r == 8'h0 && port_out_r == 16'h0))
    else $error("nonzero header fields on error status");

  // a byte held back by a full output stays in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc_go) |=> (in_vld_r && $stable(in_byte_r) && $stable(in_start_r)))
    else $error("input register lost a byte");

  // idle parser always sits at position zero
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (pos_r == 16'h0))
    else $error("idle parser with nonzero position");

  // a new result is loaded only into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(status_r)))
    else $error("pending result overwritten");

endmodule

FILE: hdl/frv_regs.sv
// APB-style configuration register file for the record validator.
// Depends on frv_pkg for register indexes and reset values.
module frv_regs import frv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  expected_version
);

  logic [7:0] version_r;
  logic       reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RESET;
    end else if (wr_en && (reg_idx == REG_VERSION)) begin
      version_r <= pwdata[7:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VERSION: prdata = {24'h0, version_r};
      default:     prdata = 32'h0;
    endcase
  end

  assign expected_version = version_r;

endmodule
